### rtl/iir_dfo_pkg.sv
package iir_dfo_pkg;

  // filter dimensions
  localparam int unsigned TAPS        = 100;
  localparam int unsigned CHANNELS    = 2;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned COEF_BITS   = 32;
  localparam int unsigned COEF_FRAC   = 24;
  localparam int unsigned ACC_BITS    = 64;
  localparam int unsigned PROD_BITS   = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned SWAP_DELAY  = 100;
  localparam int unsigned CLIP_LIMIT  = 100;
  localparam int unsigned QUIET_MAX   = 255;

  // derived widths
  localparam int unsigned CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned COEF_AW   = $clog2(TAPS);
  localparam int unsigned HIST_DEPTH = CHANNELS * TAPS;
  localparam int unsigned HIST_AW   = $clog2(HIST_DEPTH);
  localparam int unsigned CNT_W     = $clog2(2 * TAPS + 2);
  localparam int unsigned QUIET_W   = 8;
  localparam int unsigned CLIP_W    = $clog2(CLIP_LIMIT + 1);

  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;

  // operation and side codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;
  localparam logic SIDE_NUM  = 1'b0;
  localparam logic SIDE_DEN  = 1'b1;

  typedef struct packed {
    logic                          op;
    logic                          channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          coef_side;
    logic [6:0]                    coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
  } in_word_t;

  typedef struct packed {
    logic                          out_channel;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          saturated;
  } out_word_t;

endpackage

### rtl/iir_dfo_in_if.sv
interface iir_dfo_in_if;
  import iir_dfo_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/iir_dfo_out_if.sv
interface iir_dfo_out_if;
  import iir_dfo_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/iir_direct_form_one_filter.sv
// channel | dir | word
// in_i    | in  | sample to filter or pending coefficient write
// out_o   | out | filtered sample, channel and clip flag
//
// a taken sample closes the input until its word enters the output register,
// which waits while the output is stalled; the input then reopens. one shared
// multiplier does one numerator or denominator product per cycle; a table
// swap first copies the pending tables into the active ones. a coefficient
// write leaves the input open and gives no word. after reset, a pass clears
// history and tables before any word; too many clips clear the history only.
// the output register lets one finished word wait while the next is taken.
module iir_direct_form_one_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  iir_dfo_in_if.sink                 in_i,
  iir_dfo_out_if.source              out_o
);
  import iir_dfo_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_COPY  = 3'd2;
  localparam logic [2:0] ST_MAC   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // memories
  logic [COEF_BITS-1:0]   act_num_mem [TAPS];
  logic [COEF_BITS-1:0]   act_den_mem [TAPS];
  logic [COEF_BITS-1:0]   pnd_num_mem [TAPS];
  logic [COEF_BITS-1:0]   pnd_den_mem [TAPS];
  logic [SAMPLE_BITS-1:0] x_mem [HIST_DEPTH];
  logic [SAMPLE_BITS-1:0] y_mem [HIST_DEPTH];

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   init_q, init_d;
  logic [QUIET_W-1:0]     quiet_q, quiet_d;
  logic                   swap_q, swap_d;
  logic [CLIP_W-1:0]      clip_q, clip_d;
  logic [COEF_AW-1:0]     pos_q [CHANNELS];
  logic [CH_W-1:0]        ch_q;
  logic [COEF_AW-1:0]     npos_q;
  logic [COEF_AW-1:0]     k_q;
  logic [HIST_AW-1:0]     base_q;
  logic signed [ACC_BITS-1:0]  acc_q;
  logic signed [PROD_BITS-1:0] prod_q;
  logic                   v1_q, t1_q, z1_q, v2_q, neg2_q;
  logic                   out_valid_q;
  out_word_t              out_q;

  logic [COEF_BITS-1:0]   act_num_rd_q, act_den_rd_q, pnd_num_rd_q, pnd_den_rd_q;
  logic [SAMPLE_BITS-1:0] x_rd_q, y_rd_q;

  logic                   in_acc, out_free, clear_row, coef_row;
  logic [CH_W-1:0]        in_ch;
  logic [COEF_AW-1:0]     in_npos;
  logic [HIST_AW-1:0]     in_base;
  logic                   swap_now;

  // write ports
  logic                   act_we, pnd_num_we, pnd_den_we, x_we, y_we;
  logic [COEF_AW-1:0]     act_wa, pnd_num_wa, pnd_den_wa;
  logic [COEF_BITS-1:0]   act_num_wd, act_den_wd, pnd_num_wd, pnd_den_wd;
  logic [HIST_AW-1:0]     x_wa, y_wa, hist_ra;
  logic [SAMPLE_BITS-1:0] x_wd, y_wd;
  logic [COEF_AW-1:0]     coef_ra, copy_ra;

  // datapath
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [COEF_BITS-1:0]   mul_b;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]    prod_ext;
  logic                          fits, sat;
  logic [SAMPLE_BITS-1:0]        y_val;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign in_ch   = in_i.data.channel;
  assign in_npos = (pos_q[in_ch] == COEF_AW'(TAPS - 1)) ? '0 : pos_q[in_ch] + 1'b1;
  assign in_base = HIST_AW'(in_ch) * HIST_AW'(TAPS);
  assign swap_now = swap_q && (quiet_q >= QUIET_W'(SWAP_DELAY));

  assign clear_row = (state_q == ST_CLEAR);
  assign coef_row  = clear_row && init_q && (cnt_q < CNT_W'(TAPS));

  // pending table writes: clearing pass or coefficient word
  always_comb begin
    pnd_num_we = 1'b0;
    pnd_den_we = 1'b0;
    pnd_num_wa = in_i.data.coef_index[COEF_AW-1:0];
    pnd_den_wa = COEF_AW'(in_i.data.coef_index + 7'd1);
    pnd_num_wd = in_i.data.coef_value;
    pnd_den_wd = in_i.data.coef_value;
    if (coef_row) begin
      pnd_num_we = 1'b1;
      pnd_den_we = 1'b1;
      pnd_num_wa = cnt_q[COEF_AW-1:0];
      pnd_den_wa = cnt_q[COEF_AW-1:0];
      pnd_num_wd = '0;
      pnd_den_wd = (cnt_q == '0) ? COEF_ONE : '0;
    end else if (in_acc && in_i.data.op == OP_COEF) begin
      if (in_i.data.coef_side == SIDE_NUM) begin
        pnd_num_we = (in_i.data.coef_index < 7'(TAPS));
      end else begin
        pnd_den_we = (in_i.data.coef_index < 7'(TAPS - 1));
      end
    end
  end

  // active table writes: clearing pass or copy from pending
  always_comb begin
    act_we     = 1'b0;
    act_wa     = cnt_q[COEF_AW-1:0];
    act_num_wd = (cnt_q == '0) ? COEF_ONE : '0;
    act_den_wd = (cnt_q == '0) ? COEF_ONE : '0;
    if (coef_row) begin
      act_we = 1'b1;
    end else if (state_q == ST_COPY && cnt_q != '0) begin
      act_we     = 1'b1;
      act_wa     = COEF_AW'(cnt_q - 1'b1);
      act_num_wd = pnd_num_rd_q;
      act_den_wd = pnd_den_rd_q;
    end
  end

  assign copy_ra = cnt_q[COEF_AW-1:0];

  // history writes
  always_comb begin
    x_we = clear_row || (in_acc && in_i.data.op == OP_SAMPLE);
    x_wa = clear_row ? cnt_q[HIST_AW-1:0] : HIST_AW'(in_base + HIST_AW'(in_npos));
    x_wd = clear_row ? '0 : in_i.data.sample_in;
    y_we = clear_row || (state_q == ST_DONE && out_free);
    y_wa = clear_row ? cnt_q[HIST_AW-1:0] : HIST_AW'(base_q + HIST_AW'(npos_q));
    y_wd = clear_row ? '0 : y_val;
  end

  assign coef_ra = cnt_q[COEF_AW:1];
  assign hist_ra = HIST_AW'(base_q + HIST_AW'(k_q));

  // memory ports
  always_ff @(posedge clk_i) begin
    if (act_we) begin
      act_num_mem[act_wa] <= act_num_wd;
      act_den_mem[act_wa] <= act_den_wd;
    end
    act_num_rd_q <= act_num_mem[coef_ra];
    act_den_rd_q <= act_den_mem[coef_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pnd_num_we) pnd_num_mem[pnd_num_wa] <= pnd_num_wd;
    if (pnd_den_we) pnd_den_mem[pnd_den_wa] <= pnd_den_wd;
    pnd_num_rd_q <= pnd_num_mem[copy_ra];
    pnd_den_rd_q <= pnd_den_mem[copy_ra];
  end

  always_ff @(posedge clk_i) begin
    if (x_we) x_mem[x_wa] <= x_wd;
    if (y_we) y_mem[y_wa] <= y_wd;
    x_rd_q <= x_mem[hist_ra];
    y_rd_q <= y_mem[hist_ra];
  end

  // multiply stage
  assign mul_a    = t1_q ? signed'(y_rd_q) : signed'(x_rd_q);
  assign mul_b    = t1_q ? signed'(act_den_rd_q) : signed'(act_num_rd_q);
  assign prod     = mul_a * mul_b;
  assign prod_ext = ACC_BITS'(prod_q);

  always_ff @(posedge clk_i) begin
    prod_q <= z1_q ? '0 : prod;
    neg2_q <= t1_q;
    if (state_q == ST_MAC && cnt_q == '0) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= neg2_q ? acc_q - prod_ext : acc_q + prod_ext;
    end
  end

  // shift and saturate
  assign fits  = (&acc_q[ACC_BITS-1:COEF_FRAC+SAMPLE_BITS-1]) ||
                 !(|acc_q[ACC_BITS-1:COEF_FRAC+SAMPLE_BITS-1]);
  assign sat   = !fits;
  assign y_val = fits ? acc_q[COEF_FRAC+SAMPLE_BITS-1:COEF_FRAC]
               : (acc_q[ACC_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                    : {1'b0, {(SAMPLE_BITS-1){1'b1}}});

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_q.out_channel <= ch_q;
      out_q.sample_out  <= y_val;
      out_q.saturated   <= sat;
    end
  end

  // per-sample registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q   <= in_ch;
      npos_q <= in_npos;
      base_q <= in_base;
    end
    if (in_acc) begin
      k_q <= in_npos;
    end else if (state_q == ST_MAC && cnt_q[0] && cnt_q < CNT_W'(2 * TAPS)) begin
      k_q <= (k_q == '0) ? COEF_AW'(TAPS - 1) : k_q - 1'b1;
    end
    t1_q <= cnt_q[0];
    z1_q <= cnt_q[0] && (cnt_q[CNT_W-1:1] == '0);
  end

  // control
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    init_d  = init_q;
    quiet_d = quiet_q;
    swap_d  = swap_q;
    clip_d  = clip_q;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(HIST_DEPTH - 1)) begin
          state_d = ST_IDLE;
          init_d  = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d = '0;
          if (in_i.data.op == OP_COEF) begin
            quiet_d = '0;
            swap_d  = 1'b1;
          end else if (swap_now) begin
            quiet_d = '0;
            swap_d  = 1'b0;
            state_d = ST_COPY;
          end else begin
            if (quiet_q < QUIET_W'(QUIET_MAX)) quiet_d = quiet_q + 1'b1;
            state_d = ST_MAC;
          end
        end
      end
      ST_COPY: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(TAPS)) begin
          cnt_d   = '0;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(2 * TAPS + 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
          if (sat) begin
            if (clip_q >= CLIP_W'(CLIP_LIMIT)) begin
              clip_d  = '0;
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end else begin
              clip_d = clip_q + 1'b1;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      init_q      <= 1'b1;
      quiet_q     <= '0;
      swap_q      <= 1'b0;
      clip_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) pos_q[i] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      init_q  <= init_d;
      quiet_q <= quiet_d;
      swap_q  <= swap_d;
      clip_q  <= clip_d;
      v1_q    <= (state_q == ST_MAC) && (cnt_q < CNT_W'(2 * TAPS));
      v2_q    <= v1_q;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q  <= 1'b1;
        pos_q[ch_q]  <= npos_q;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/iir_dfo_checker.sv
module iir_dfo_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  in_op_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input iir_dfo_pkg::out_word_t out_data_i
);
  import iir_dfo_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output word changed while stalled");

  // coefficient word leaves the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_op_i == OP_COEF |=> in_ready_i)
    else $error("coefficient write blocked the input");

  // sample word closes the input while it is filtered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_op_i == OP_SAMPLE |=> !in_ready_i)
    else $error("input open during filtering");

  // no result right after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("result appeared too early");

endmodule

bind iir_direct_form_one_filter iir_dfo_checker u_iir_dfo_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_op_i    (in_i.data.op),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);

### tb/iir_dfo_checker.sv
module iir_dfo_scoreboard
  import iir_dfo_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  iir_dfo_in_if in_b,
  iir_dfo_out_if out_b,
  output int    fail_count_o,
  output int    pending_o,
  output int    filtered_count_o,
  output int    clip_seen_o,
  output int    swap_seen_o,
  output int    coef_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // predictor state
  logic signed [COEF_BITS-1:0]   live_num[TAPS];
  logic signed [COEF_BITS-1:0]   live_den[TAPS];
  logic signed [COEF_BITS-1:0]   next_num[TAPS];
  logic signed [COEF_BITS-1:0]   next_den[TAPS];
  logic signed [SAMPLE_BITS-1:0] x_ring[CHANNELS][TAPS];
  logic signed [SAMPLE_BITS-1:0] y_ring[CHANNELS][TAPS];
  int unsigned                   newest[CHANNELS];
  int unsigned                   quiet;
  bit                            swap_armed;
  int unsigned                   clips;

  out_word_t filtered_q[$];

  assign pending_o = filtered_q.size();

  task automatic clear_rings();
    for (int c = 0; c < CHANNELS; c++) begin
      for (int t = 0; t < TAPS; t++) begin
        x_ring[c][t] = '0;
        y_ring[c][t] = '0;
      end
    end
  endtask

  initial begin
    fail_count_o     = 0;
    filtered_count_o = 0;
    clip_seen_o      = 0;
    swap_seen_o      = 0;
    coef_seen_o      = 0;
    for (int t = 0; t < TAPS; t++) begin
      live_num[t] = '0;
      live_den[t] = '0;
      next_num[t] = '0;
      next_den[t] = '0;
    end
    live_num[0] = COEF_ONE;
    live_den[0] = COEF_ONE;
    next_den[0] = COEF_ONE;
    clear_rings();
    for (int c = 0; c < CHANNELS; c++) newest[c] = 0;
    quiet      = 0;
    swap_armed = 0;
    clips      = 0;
  end

  // advance the filter by one accepted word, queue the expected output of a sample
  task automatic filter_word(input in_word_t w);
    logic signed [ACC_BITS-1:0] acc;
    logic signed [ACC_BITS-1:0] xs;
    logic signed [ACC_BITS-1:0] ys;
    logic signed [ACC_BITS-1:0] cn;
    logic signed [ACC_BITS-1:0] cd;
    logic signed [ACC_BITS-1:0] y;
    int unsigned                ch;
    int unsigned                pos;
    int unsigned                k;
    bit                         sat;
    out_word_t                  r;
    if (w.op == OP_COEF) begin
      coef_seen_o++;
      if (w.coef_side == SIDE_NUM) begin
        if (w.coef_index < TAPS) next_num[w.coef_index] = w.coef_value;
      end else begin
        if (w.coef_index + 1 < TAPS) next_den[w.coef_index + 1] = w.coef_value;
      end
      quiet      = 0;
      swap_armed = 1;
      return;
    end
    if (swap_armed && quiet >= SWAP_DELAY) begin
      live_num   = next_num;
      live_den   = next_den;
      quiet      = 0;
      swap_armed = 0;
      swap_seen_o++;
    end else if (quiet < QUIET_MAX) begin
      quiet++;
    end
    ch  = w.channel % CHANNELS;
    pos = (newest[ch] + 1) % TAPS;
    x_ring[ch][pos] = w.sample_in;
    acc = '0;
    for (int j = 0; j < TAPS; j++) begin
      k  = (pos + TAPS - j) % TAPS;
      xs = x_ring[ch][k];
      cn = live_num[j];
      acc = acc + xs * cn;
      if (j != 0) begin
        ys  = y_ring[ch][k];
        cd  = live_den[j];
        acc = acc - ys * cd;
      end
    end
    y   = acc >>> COEF_FRAC;
    sat = 0;
    if (y > 64'sd8388607) begin
      y   = 64'sd8388607;
      sat = 1;
    end else if (y < -64'sd8388608) begin
      y   = -64'sd8388608;
      sat = 1;
    end
    y_ring[ch][pos] = y[SAMPLE_BITS-1:0];
    newest[ch]      = pos;
    if (sat) begin
      clip_seen_o++;
      if (clips >= CLIP_LIMIT) begin
        clips = 0;
        clear_rings();
      end else begin
        clips++;
      end
    end
    r.out_channel = ch[0];
    r.sample_out  = y[SAMPLE_BITS-1:0];
    r.saturated   = sat;
    filtered_q.push_back(r);
  endtask

  // watch both channels, predict on input, compare on output
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni) begin
      if (in_b.valid && in_b.ready) filter_word(in_b.data);
      if (out_b.valid && out_b.ready) begin
        filtered_count_o++;
        if (filtered_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected word %h", $time, out_b.data);
        end else begin
          e = filtered_q.pop_front();
          if (out_b.data.out_channel !== e.out_channel) begin
            fail_count_o++;
            $display("%0t: out_channel expected %0d actual %0d", $time,
                     e.out_channel, out_b.data.out_channel);
          end
          if (out_b.data.sample_out !== e.sample_out) begin
            fail_count_o++;
            $display("%0t: sample_out expected %0d actual %0d", $time,
                     e.sample_out, out_b.data.sample_out);
          end
          if (out_b.data.saturated !== e.saturated) begin
            fail_count_o++;
            $display("%0t: saturated expected %0d actual %0d", $time,
                     e.saturated, out_b.data.saturated);
          end
        end
      end
    end
  end

endmodule

### tb/tb_iir_direct_form_one_filter.sv
module tb_iir_direct_form_one_filter;
  timeunit 1ns;
  timeprecision 1ps;
  import iir_dfo_pkg::*;

  localparam int unsigned WORD_GOAL   = 1550;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned HOLD_CYCLES = 3000;

  logic clk_i;
  logic rst_ni;

  iir_dfo_in_if  in_b ();
  iir_dfo_out_if out_b ();

  int fail_count;
  int pending;
  int filtered_count;
  int clip_seen;
  int swap_seen;
  int coef_seen;

  int unsigned words_sent;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  int unsigned cycles = 0;

  iir_direct_form_one_filter u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_b),
    .out_o  (out_b)
  );

  iir_dfo_scoreboard u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_b             (in_b),
    .out_b            (out_b),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .filtered_count_o (filtered_count),
    .clip_seen_o      (clip_seen),
    .swap_seen_o      (swap_seen),
    .coef_seen_o      (coef_seen)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_req && hold_left < HOLD_CYCLES) begin
      hold_left <= hold_left + 1;
      out_b.ready <= 1'b0;
    end else begin
      out_b.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one word until taken, after optional idle cycles
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_b.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_b.valid <= 1'b1;
    in_b.data  <= w;
    do @(posedge clk_i); while (!in_b.ready);
    words_sent++;
  endtask

  function automatic in_word_t sample_word(input logic ch, input logic [23:0] s);
    in_word_t w;
    w            = in_word_t'({$urandom, $urandom});
    w.op         = OP_SAMPLE;
    w.channel    = ch;
    w.sample_in  = s;
    return w;
  endfunction

  function automatic in_word_t coef_word(input logic side, input logic [6:0] idx,
                                         input logic [31:0] v);
    in_word_t w;
    w            = in_word_t'({$urandom, $urandom});
    w.op         = OP_COEF;
    w.coef_side  = side;
    w.coef_index = idx;
    w.coef_value = v;
    return w;
  endfunction

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(4))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(input int unsigned mode);
    case (mode)
      0: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      1: return ($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000;
      2: return 32'($urandom_range(1 << 26));
      default: return $urandom;
    endcase
  endfunction

  // set the idling mix from how far the run has got
  task automatic set_phase();
    case ((words_sent * 4) / WORD_GOAL)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
      default: begin send_idle_pct = 14; recv_stall_pct = 14; end
    endcase
  endtask

  // stimulus
  initial begin
    int unsigned mode;
    int unsigned run;
    words_sent    = 0;
    send_idle_pct = 0;
    rst_ni        = 1'b0;
    in_b.valid    <= 1'b0;
    in_b.data     <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: unity filter extremes on both channels
    send_word(sample_word(1'b0, 24'h7FFFFF));
    send_word(sample_word(1'b1, 24'h800000));
    send_word(sample_word(1'b0, 24'h000000));
    send_word(sample_word(1'b1, 24'hFFFFFF));
    send_word(sample_word(1'b0, 24'h000001));
    // coefficient writes, including the ignored indexes
    send_word(coef_word(SIDE_NUM, 7'd0, 32'h7FFFFFFF));
    send_word(coef_word(SIDE_NUM, 7'd99, 32'h80000000));
    send_word(coef_word(SIDE_NUM, 7'd127, 32'hFFFFFFFF));
    send_word(coef_word(SIDE_DEN, 7'd0, 32'h00400000));
    send_word(coef_word(SIDE_DEN, 7'd98, 32'hFFC00000));
    send_word(coef_word(SIDE_DEN, 7'd99, 32'h7FFFFFFF));
    send_word(coef_word(SIDE_DEN, 7'd127, 32'h80000000));
    // samples within the quiet period, still through the unity tables
    repeat (13) send_word(sample_word(1'($urandom_range(1)), rand_sample()));

    // random: coefficient bursts and sample runs
    while (words_sent < WORD_GOAL) begin
      set_phase();
      if (!hold_req && recv_stall_pct == 62) hold_req = 1'b1;
      if ($urandom_range(99) < 25) begin
        mode = $urandom_range(3);
        run  = $urandom_range(1, 8);
        repeat (run) begin
          if ($urandom_range(9) == 0)
            send_word(coef_word(1'($urandom_range(1)), 7'($urandom), $urandom));
          else
            send_word(coef_word(1'($urandom_range(1)), 7'($urandom_range(15)),
                                rand_coef(mode)));
        end
      end else begin
        run = $urandom_range(10, 140);
        repeat (run) send_word(sample_word(1'($urandom_range(1)), rand_sample()));
      end
    end
    in_b.valid <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    $display("sent %0d words: %0d coefficient writes, %0d filtered samples checked",
             words_sent, coef_seen, filtered_count);
    $display("table swaps %0d, clipped outputs %0d", swap_seen, clip_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/iir_dfo_pkg.sv
rtl/iir_dfo_in_if.sv
rtl/iir_dfo_out_if.sv
rtl/iir_direct_form_one_filter.sv
rtl/iir_dfo_checker.sv
tb/iir_dfo_checker.sv
tb/tb_iir_direct_form_one_filter.sv
